[hdl/mwcl4_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mwcl4_pkg;

   localparam int unsigned LAG_DEPTH    = 4;
   localparam int unsigned WARMUP_WORDS = 6;
   localparam int unsigned WARM_W       = $clog2(WARMUP_WORDS);

   localparam logic [15:0] MWC_MULT   = 16'd227;
   localparam logic [7:0]  CARRY_SEED = 8'd1;

   localparam logic OP_SEED = 1'b0;
   localparam logic OP_NEXT = 1'b1;

   typedef struct packed {
      logic [LAG_DEPTH-1:0][7:0] lag;
      logic [7:0]                carry;
   } gen_state_type;

endpackage
`default_nettype wire

[hdl/mwcl4_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface mwcl4_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] seed_value;

   modport source (output valid, output operation, output seed_value, input ready);
   modport sink (input valid, input operation, input seed_value, output ready);
endinterface

interface mwcl4_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink (input valid, input random_word, output ready);
endinterface
`default_nettype wire

[hdl/mwc_lag4_byte_prng_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Lag-4 multiply-with-carry byte generator, one 32-bit word per item.
//
// req_chan carries items: operation selects seed (load seed_value, set carry
// to one, run six warm-up words, no result) or next (one random_word on
// rsp_chan). Both channels use valid/ready; an item moves when both are high.
//
// A next item goes into an input register, then one pass through the four
// byte steps writes the generator state and the result register: the result
// is registered when the item leaves the input register. Next items stream
// at one per cycle while rsp_chan does not stall and no warm-up runs.
// A seed item leaves the input register with the first warm-up word; the
// other warm-up words follow, one word per cycle through the same step
// logic, and the next item is processed only after the warm-up ends.
//
// When rsp_chan stalls, the result register holds and the input register
// keeps one item; req_chan.ready drops while that item cannot move on, under
// a stall or during warm-up.
// Reset clears the lag bytes to zero and the carry to one; an unseeded
// generator runs from that state.
module mwc_lag4_byte_prng_top (
   input  logic clock,
   input  logic reset,
   mwcl4_req_if.sink   req_chan,
   mwcl4_rsp_if.source rsp_chan
);
   import mwcl4_pkg::*;

   logic              stage_vld_ff, stage_vld_in;
   logic              stage_op_ff;
   logic [31:0]       stage_seed_ff;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [31:0]       rsp_word_ff;
   logic [WARM_W-1:0] warm_ff, warm_in;
   gen_state_type     state_ff, state_in;
   gen_state_type     core_cur, core_nxt;
   logic [31:0]       core_word;
   logic              stage_fire;
   logic              req_take;
   logic              step_en;

   assign stage_fire = stage_vld_ff && (warm_ff == '0) &&
                       (stage_op_ff == OP_SEED || !rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_vld_ff || stage_fire;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      core_cur = state_ff;
      if (stage_fire && stage_op_ff == OP_SEED) begin
         core_cur.lag   = stage_seed_ff;
         core_cur.carry = CARRY_SEED;
      end
   end

   mwcl4_core u_core (
      .cur_state (core_cur),
      .nxt_state (core_nxt),
      .word      (core_word)
   );

   assign step_en  = stage_fire || (warm_ff != '0);
   assign state_in = step_en ? core_nxt : state_ff;

   always_comb begin
      warm_in = warm_ff;
      if (stage_fire && stage_op_ff == OP_SEED) begin
         warm_in = WARM_W'(WARMUP_WORDS - 1);
      end else if (warm_ff != '0) begin
         warm_in = warm_ff - 1'b1;
      end
   end

   always_comb begin
      stage_vld_in = stage_vld_ff;
      if (req_take) begin
         stage_vld_in = 1'b1;
      end else if (stage_fire) begin
         stage_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (stage_fire && stage_op_ff == OP_NEXT) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff   <= 1'b0;
         rsp_vld_ff     <= 1'b0;
         warm_ff        <= '0;
         state_ff.lag   <= '0;
         state_ff.carry <= CARRY_SEED;
      end else begin
         stage_vld_ff <= stage_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
         warm_ff      <= warm_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_op_ff   <= req_chan.operation;
         stage_seed_ff <= req_chan.seed_value;
      end
      if (stage_fire && stage_op_ff == OP_NEXT) begin
         rsp_word_ff <= core_word;
      end
   end

   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.random_word = rsp_word_ff;

endmodule
`default_nettype wire

[hdl/mwcl4_core.sv]
`timescale 1ns / 1ps
`default_nettype none
module mwcl4_core (
   input  mwcl4_pkg::gen_state_type cur_state,
   output mwcl4_pkg::gen_state_type nxt_state,
   output logic [31:0]              word
);
   import mwcl4_pkg::*;

   // Four chained byte steps; the carry and the shifted lag bytes pass between them.
   always_comb begin
      logic [LAG_DEPTH-1:0][7:0] x;
      logic [7:0]                c;
      logic [15:0]               t;
      logic [7:0]                mix;
      x    = cur_state.lag;
      c    = cur_state.carry;
      word = '0;
      for (int k = 0; k < LAG_DEPTH; k++) begin
         t    = {8'd0, x[3]} * MWC_MULT;
         mix  = (x[2] ^ x[1]) + (x[0] ^ t[15:8]);
         t    = t + {8'd0, c};
         x[3] = x[2];
         x[2] = x[1];
         x[1] = x[0];
         x[0] = t[7:0];
         c    = t[15:8];
         word = {word[23:0], mix};
      end
      nxt_state.lag   = x;
      nxt_state.carry = c;
   end

endmodule
`default_nettype wire
